// ===== sv/dqi_pkg.sv =====
// Shared types and constants for the double-ended queue with index access.
// Holds the field widths, command and status codes, and the controller command struct.
// No dependencies.
`default_nettype none

package dqi_pkg;

    // Field widths of one transaction
    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 4;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Packed stream widths, rounded up to whole bytes
    localparam int IN_BITS  = CMD_W + VALUE_W + INDEX_W;
    localparam int OUT_BITS = DATA_W + STATUS_W + COUNT_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_TAIL  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_HEAD   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_FRONT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ_BACK  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_READ_INDEX = 3'd6;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the incoming transaction
        logic exec;   // update the ring and access the slot memory
    } t_dp_cmd;

endpackage

`default_nettype wire

// ===== sv/dqi_dp.sv =====
// Datapath of the deque: slot memory, head position, element count and result registers.
// Depends on dqi_pkg.
`default_nettype none

module dqi_dp
    import dqi_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    input  wire logic [CMD_W-1:0]    i_command,
    input  wire logic [VALUE_W-1:0]  i_value,
    input  wire logic [INDEX_W-1:0]  i_index,
    output logic      [DATA_W-1:0]   o_data,
    output logic      [STATUS_W-1:0] o_status,
    output logic      [COUNT_W-1:0]  o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int XW = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
    localparam int KW = (CW > COUNT_W) ? CW : COUNT_W;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];

    logic [CMD_W-1:0]      r_command;
    logic [DATA_WIDTH-1:0] r_value;
    logic [INDEX_W-1:0]    r_index;
    logic [AW-1:0]         r_head;
    logic [CW-1:0]         r_held;
    logic [STATUS_W-1:0]   r_status;
    logic                  r_is_read;
    logic [DATA_WIDTH-1:0] r_rdata;

    logic [AW-1:0]       n_head;
    logic [CW-1:0]       n_held;
    logic [STATUS_W-1:0] n_status;

    logic [XW-1:0] w_val_ext;
    logic [XW-1:0] w_rd_ext;
    logic [KW-1:0] w_cnt_ext;
    logic [IW-1:0] w_idx_ext;
    logic [IW-1:0] w_held_ext;
    logic          w_empty;
    logic          w_full;
    logic          w_out_range;
    logic [AW-1:0] w_head_dec;
    logic [AW-1:0] w_head_inc;
    logic [CW-1:0] w_off;
    logic [CW:0]   w_sum;
    logic [CW:0]   w_wrap;
    logic [AW-1:0] w_ring;
    logic [AW-1:0] w_addr;
    logic          w_we;
    logic          w_re;

    assign w_val_ext   = XW'(i_value);
    assign w_empty     = (r_held == '0);
    assign w_full      = (r_held == CW'(DEPTH));
    assign w_idx_ext   = IW'(r_index);
    assign w_held_ext  = IW'(r_held);
    assign w_out_range = (w_idx_ext >= w_held_ext);
    assign w_head_dec  = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;
    assign w_head_inc  = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;

    // Offset from the front for the ring address
    always_comb begin
        case (r_command)
            CMD_PUSH_TAIL:  w_off = r_held;
            CMD_READ_BACK:  w_off = r_held - 1'b1;
            CMD_READ_INDEX: w_off = w_idx_ext[CW-1:0];
            default:        w_off = '0;
        endcase
    end

    // head + offset stays below twice the depth for every access made: one compare and subtract
    assign w_sum  = (CW + 1)'(r_head) + (CW + 1)'(w_off);
    assign w_wrap = (w_sum >= (CW + 1)'(DEPTH)) ? w_sum - (CW + 1)'(DEPTH) : w_sum;
    assign w_ring = w_wrap[AW-1:0];

    always_comb begin
        n_head   = r_head;
        n_held   = r_held;
        n_status = ST_OK;
        w_addr   = w_ring;
        w_we     = 1'b0;
        w_re     = 1'b0;
        case (r_command)
            CMD_PUSH_TAIL: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_we   = 1'b1;
                    n_held = r_held + 1'b1;
                end
            end
            CMD_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_we   = 1'b1;
                    w_addr = w_head_dec;
                    n_head = w_head_dec;
                    n_held = r_held + 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_held = r_held - 1'b1;
                end
            end
            CMD_POP_HEAD: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_head = w_head_inc;
                    n_held = r_held - 1'b1;
                end
            end
            CMD_READ_FRONT, CMD_READ_BACK: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_re = 1'b1;
                end
            end
            CMD_READ_INDEX: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else if (w_out_range) begin
                    n_status = ST_RANGE;
                end else begin
                    w_re = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_held <= '0;
        end else if (i_cmd.exec) begin
            r_head <= n_head;
            r_held <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command <= i_command;
            r_value   <= w_val_ext[DATA_WIDTH-1:0];
            r_index   <= i_index;
        end
        if (i_cmd.exec) begin
            r_status  <= n_status;
            r_is_read <= w_re;
        end
    end

    // Slot memory: one write or one registered read per transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_we) begin
            r_mem[w_addr] <= r_value;
        end
        if (i_cmd.exec && w_re) begin
            r_rdata <= r_mem[w_addr];
        end
    end

    assign w_rd_ext  = XW'(r_rdata);
    assign w_cnt_ext = KW'(r_held);
    assign o_data    = r_is_read ? w_rd_ext[DATA_W-1:0] : '0;
    assign o_status  = r_status;
    assign o_count   = w_cnt_ext[COUNT_W-1:0];

endmodule

`default_nettype wire

// ===== sv/dqi_ctrl.sv =====
// Controller of the deque: sequences capture, execute and result hand-off per transaction.
// Depends on dqi_pkg.
`default_nettype none

module dqi_ctrl
    import dqi_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_out_ready,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_dp_cmd   o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: n_state = S_RESP;
            S_RESP: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_RESP);
    assign o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec  = (r_state == S_EXEC);

endmodule

`default_nettype wire

// ===== sv/double_ended_queue_with_index.sv =====
// Top level of the bounded double-ended queue with indexed read.
// Depends on dqi_pkg, dqi_ctrl and dqi_dp.
//
// Usage:
//   Commands enter on the s_axis channel; each transaction carries command,
//   value and index. Every command answers with exactly one transaction on
//   the m_axis channel carrying read data, status and the element count
//   after the command.
//   Sequencing: the command is captured at its accepting edge, the next
//   cycle updates the ring and accesses the slot memory, and the result is
//   offered right after that edge. The block takes no new command until
//   the result transaction completes, so commands pass one at a time
//   (capture, execute, result hand-off).
//   The single-port slot memory with its registered read sets the execute cycle.
//   When the receiver stalls, the result holds on m_axis and s_axis_tready
//   stays low until the result transaction completes.
//   Reset (synchronous, active low) empties the queue and returns to idle;
//   slot contents are left as they were and are never read before written.
`default_nettype none

module double_ended_queue_with_index
    import dqi_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [2:0] command, [34:3] value, [38:35] index, [39] zero
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [31:0] data, [33:32] status, [38:34] count, [39] zero
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_dp_cmd             w_cmd;
    logic [DATA_W-1:0]   w_data;
    logic [STATUS_W-1:0] w_status;
    logic [COUNT_W-1:0]  w_count;

    // Sequence each transaction: capture, execute, then offer the result
    dqi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    // Ring state, slot memory and result registers
    dqi_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_command (s_axis_tdata[CMD_W-1:0]),
        .i_value   (s_axis_tdata[CMD_W +: VALUE_W]),
        .i_index   (s_axis_tdata[CMD_W + VALUE_W +: INDEX_W]),
        .o_data    (w_data),
        .o_status  (w_status),
        .o_count   (w_count)
    );

    // Pack the result, lowest field first, zero fill to the byte
    assign m_axis_tdata = OUT_TDATA_W'({w_count, w_status, w_data});

endmodule

`default_nettype wire

// ===== bench/double_ended_queue_with_index_test.sv =====
// Self-checking bench for double_ended_queue_with_index: directed corner commands, then
// phased random traffic with idle gaps and stalls on both stream channels.
// Depends on dqi_pkg and the double_ended_queue_with_index RTL.
`default_nettype none

module double_ended_queue_with_index_test;
    import dqi_pkg::*;

    localparam int RING_DEPTH     = 16;
    localparam int PTR_W          = 4;
    localparam int RANDOM_CMDS    = 700;
    localparam int CHOKE_CYCLES   = 400;   // one long receiver hold-off
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transaction on either side
    localparam int DRAIN_CYCLES   = 12;    // settle time after the last result

    // No-operation command: answers ok with the count unchanged
    localparam logic [CMD_W-1:0] CMD_NOP = 3'd7;

    // Random traffic phases
    localparam int PH_FILL  = 0;
    localparam int PH_DRAIN = 1;
    localparam int PH_MIXED = 2;
    localparam int PH_READS = 3;

    // One command transaction, command in the lowest bits
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
        logic [CMD_W-1:0]   cmd;
    } cmd_item_t;

    // One answer transaction, data in the lowest bits
    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   data;
    } deque_answer_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [2:0] command, [34:3] value, [38:35] index, [39] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [31:0] data, [33:32] status, [38:34] count, [39] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    double_ended_queue_with_index #(
        .DEPTH      (RING_DEPTH),
        .DATA_WIDTH (DATA_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Shadow deque: ring storage, front position and element count
    logic [DATA_W-1:0]  ring_mem [RING_DEPTH];
    logic [PTR_W-1:0]   ring_head = '0;
    logic [COUNT_W-1:0] ring_held = '0;

    cmd_item_t     cmds_pending[$];   // commands not yet offered to the block
    deque_answer_t answers_due[$];    // predicted answers, oldest first

    int  error_count   = 0;
    int  results_seen  = 0;
    int  quiet_cycles  = 0;
    bit  cmd_taken     = 1'b0;   // command transaction completed at the last rising edge
    bit  all_settled   = 1'b0;
    int  src_gap_left  = 0;
    bit  src_calm      = 1'b0;
    int  sink_stall    = 0;
    bit  sink_calm     = 1'b0;
    int  choke_left    = 0;
    bit  choke_done    = 1'b0;

    // Apply one command to the shadow deque and return the answer it should produce.
    function automatic deque_answer_t deque_apply(cmd_item_t c);
        deque_answer_t a;
        logic [PTR_W-1:0] slot;
        a = '0;
        case (c.cmd)
            CMD_PUSH_TAIL: begin
                if (ring_held == RING_DEPTH) begin
                    a.status = ST_FULL;
                end else begin
                    slot = ring_head + ring_held[PTR_W-1:0];
                    ring_mem[slot] = c.value;
                    ring_held = ring_held + 1'b1;
                end
            end
            CMD_PUSH_FRONT: begin
                if (ring_held == RING_DEPTH) begin
                    a.status = ST_FULL;
                end else begin
                    ring_head = ring_head - 1'b1;
                    ring_mem[ring_head] = c.value;
                    ring_held = ring_held + 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (ring_held == 0) a.status = ST_EMPTY;
                else ring_held = ring_held - 1'b1;
            end
            CMD_POP_HEAD: begin
                if (ring_held == 0) begin
                    a.status = ST_EMPTY;
                end else begin
                    ring_head = ring_head + 1'b1;
                    ring_held = ring_held - 1'b1;
                end
            end
            CMD_READ_FRONT: begin
                if (ring_held == 0) a.status = ST_EMPTY;
                else a.data = ring_mem[ring_head];
            end
            CMD_READ_BACK: begin
                if (ring_held == 0) begin
                    a.status = ST_EMPTY;
                end else begin
                    slot = ring_head + ring_held[PTR_W-1:0] - 1'b1;
                    a.data = ring_mem[slot];
                end
            end
            CMD_READ_INDEX: begin
                if (ring_held == 0) begin
                    a.status = ST_EMPTY;
                end else if ({1'b0, c.index} >= ring_held) begin
                    a.status = ST_RANGE;
                end else begin
                    slot = ring_head + c.index;
                    a.data = ring_mem[slot];
                end
            end
            default: ;  // no operation
        endcase
        a.count = ring_held;
        return a;
    endfunction

    task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d)",
                 what, got, want, results_seen);
        error_count++;
    endtask

    task automatic add_cmd(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                           input logic [INDEX_W-1:0] index);
        cmd_item_t c;
        c.cmd   = cmd;
        c.value = value;
        c.index = index;
        cmds_pending.insert(cmds_pending.size(), c);
    endtask

    // Values lean toward the extremes now and then
    function automatic logic [VALUE_W-1:0] random_value();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    // Pick a command whose mix depends on the phase: fill phases mostly push, drain
    // phases mostly pop, so the queue regularly reaches both full and empty.
    function automatic cmd_item_t random_cmd(int phase);
        cmd_item_t c;
        int r;
        r = $urandom_range(0, 99);
        case (phase)
            PH_FILL: begin
                if (r < 85) c.cmd = CMD_W'($urandom_range(CMD_PUSH_TAIL, CMD_PUSH_FRONT));
                else c.cmd = CMD_W'($urandom_range(CMD_POP_BACK, CMD_NOP));
            end
            PH_DRAIN: begin
                if (r < 85) c.cmd = CMD_W'($urandom_range(CMD_POP_BACK, CMD_POP_HEAD));
                else c.cmd = CMD_W'($urandom_range(CMD_PUSH_TAIL, CMD_NOP));
            end
            PH_READS: begin
                if (r < 60) c.cmd = CMD_W'($urandom_range(CMD_READ_FRONT, CMD_READ_INDEX));
                else if (r < 80) c.cmd = CMD_W'($urandom_range(CMD_PUSH_TAIL, CMD_PUSH_FRONT));
                else c.cmd = CMD_W'($urandom_range(CMD_POP_BACK, CMD_POP_HEAD));
            end
            default: c.cmd = CMD_W'($urandom_range(CMD_PUSH_TAIL, CMD_NOP));
        endcase
        c.value = random_value();
        c.index = INDEX_W'($urandom_range(0, RING_DEPTH - 1));
        return c;
    endfunction

    // Mostly short gaps, a few long ones; calm stretches offer back to back.
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Monitor: check answers, then predict for any command taken at this edge.
    always @(posedge i_clk) begin
        deque_answer_t got;
        deque_answer_t want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[OUT_BITS-1:0];
                if (answers_due.size() == 0) begin
                    flag_mismatch("answer with none outstanding", got.data, '0);
                end else begin
                    want = answers_due[0];
                    answers_due.delete(0);
                    if (got.data !== want.data) flag_mismatch("data", got.data, want.data);
                    if (got.status !== want.status)
                        flag_mismatch("status", DATA_W'(got.status), DATA_W'(want.status));
                    if (got.count !== want.count)
                        flag_mismatch("count", DATA_W'(got.count), DATA_W'(want.count));
                end
                results_seen++;
            end
            cmd_taken = s_axis_tvalid && s_axis_tready;
            if (cmd_taken)
                answers_due.insert(answers_due.size(),
                                   deque_apply(s_axis_tdata[IN_BITS-1:0]));
            if (cmd_taken || (m_axis_tvalid && m_axis_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            all_settled = (cmds_pending.size() == 0) && !s_axis_tvalid
                          && (answers_due.size() == 0);
        end
    end

    // Driver: advance to the next pending command once the current one is taken,
    // inserting random idle gaps between transactions.
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || cmd_taken)) begin
            if (src_gap_left > 0) begin
                src_gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (cmds_pending.size() > 0) begin
                s_axis_tdata  <= {{(IN_TDATA_W - IN_BITS){1'b0}}, cmds_pending[0]};
                cmds_pending.delete(0);
                s_axis_tvalid <= 1'b1;
                if ($urandom_range(0, 59) == 0) src_calm = !src_calm;
                src_gap_left = pick_gap(src_calm);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off so the block backs up
    // and drops its input ready while the driver keeps offering.
    always @(negedge i_clk) begin
        int r;
        if (i_rst_n) begin
            if (choke_left > 0) begin
                choke_left--;
                m_axis_tready <= 1'b0;
            end else if (!choke_done && results_seen >= 40) begin
                choke_done = 1'b1;
                choke_left = CHOKE_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else if (sink_stall > 0) begin
                sink_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                if ($urandom_range(0, 99) == 0) sink_calm = !sink_calm;
                r = $urandom_range(0, 99);
                if (!sink_calm && r < 20) begin
                    sink_stall = $urandom_range(0, 2);
                    m_axis_tready <= 1'b0;
                end else if (!sink_calm && r < 23) begin
                    sink_stall = $urandom_range(9, 39);
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // Watchdog: end the run when neither side has moved for too long.
    initial begin
        do @(negedge i_clk); while (quiet_cycles < WATCHDOG_LIMIT);
        $display("double_ended_queue_with_index regression: fail");
        $finish;
    end

    initial begin
        int random_made;
        int phase;
        int span;

        // Empty queue: every pop and read reports empty, no-op leaves count at zero
        add_cmd(CMD_POP_BACK,   32'h1234_5678, 4'd0);
        add_cmd(CMD_POP_HEAD,   32'h0,         4'd0);
        add_cmd(CMD_READ_FRONT, 32'hFFFF_FFFF, 4'd0);
        add_cmd(CMD_READ_BACK,  32'h0,         4'd15);
        add_cmd(CMD_READ_INDEX, 32'h0,         4'd0);
        add_cmd(CMD_NOP,        32'hFFFF_FFFF, 4'd15);
        // Extreme values from both ends, then reads across the held range
        add_cmd(CMD_PUSH_TAIL,  32'hFFFF_FFFF, 4'd15);
        add_cmd(CMD_PUSH_FRONT, 32'h0,         4'd0);
        add_cmd(CMD_PUSH_TAIL,  32'hA5A5_5A5A, 4'd0);
        add_cmd(CMD_READ_FRONT, 32'h0,         4'd0);
        add_cmd(CMD_READ_BACK,  32'h0,         4'd0);
        add_cmd(CMD_READ_INDEX, 32'h0,         4'd1);
        add_cmd(CMD_READ_INDEX, 32'h0,         4'd2);
        // Index at and past the count: out of range
        add_cmd(CMD_READ_INDEX, 32'h0,         4'd3);
        add_cmd(CMD_READ_INDEX, 32'hFFFF_FFFF, 4'd15);
        add_cmd(CMD_NOP,        32'h0,         4'd0);
        add_cmd(CMD_POP_BACK,   32'h0,         4'd0);
        add_cmd(CMD_POP_HEAD,   32'h0,         4'd0);
        add_cmd(CMD_READ_FRONT, 32'h0,         4'd0);
        add_cmd(CMD_POP_HEAD,   32'h0,         4'd0);
        add_cmd(CMD_POP_HEAD,   32'h0,         4'd0);

        // Random phases; fill and drain runs push the ring past full and empty
        random_made = 0;
        while (random_made < RANDOM_CMDS) begin
            phase = $urandom_range(PH_FILL, PH_READS);
            span  = $urandom_range(15, 60);
            repeat (span) begin
                cmds_pending.insert(cmds_pending.size(), random_cmd(phase));
                random_made++;
            end
        end

        // Hold reset low, then release it between rising edges
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk); while (!all_settled);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (answers_due.size() != 0)
            flag_mismatch("answers never delivered", '0, DATA_W'(answers_due.size()));

        if (error_count == 0) begin
            $display("double_ended_queue_with_index regression: pass");
        end else begin
            $display("double_ended_queue_with_index regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
